// ===== src/gpm_pkg.sv =====
// Shared types, constants and helpers for the glob path matcher.
// No dependencies; imported by every module of the block.
package gpm_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int MAX_TEXT    = 256;
  localparam int PAW = $clog2(MAX_PATTERN);
  localparam int TAW = $clog2(MAX_TEXT);
  localparam int PLW = PAW + 1;
  localparam int TLW = TAW + 1;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUES  = 8'h3F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] SEP_RESET = 8'h2F;

  localparam logic [1:0] REG_DOT_GLOB  = 2'd0;
  localparam logic [1:0] REG_CASE_FOLD = 2'd1;
  localparam logic [1:0] REG_PATH_SEP  = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_PAT_BYTE = 2'd1,
    CMD_TXT_BYTE = 2'd2,
    CMD_EVAL     = 2'd3
  } gpm_code_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
  } gpm_item_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } gpm_result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_DECIDE, S_LIT, S_BT, S_BT_CHK, S_CLS_INV, S_CLS_STEP,
    S_CLS_ELEM, S_CLS_RANGE, S_CLS_END, S_TAIL, S_TAIL_CHK
  } gpm_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_INIT, OP_FETCH, OP_STAR, OP_ADV, OP_LIT_ADV, OP_ESC,
    OP_CLS_START, OP_CLS_INV, OP_CLS_STEP, OP_CLS_ELEM, OP_RREAD, OP_CLS_RANGE,
    OP_CLS_DASH, OP_CLS_ADV, OP_BT_READ, OP_BT, OP_TAIL_RD, OP_JINC, OP_FINISH
  } gpm_op_t;

  typedef struct packed {
    gpm_op_t op;
    logic    res_match;
  } gpm_cmd_t;

  typedef struct packed {
    logic ovf;
    logic i_lt_n;
    logic j_lt_m;
    logic j1_lt_m;
    logic pmark_zero;
    logic p_star;
    logic p_ques;
    logic p_lbrk;
    logic p_bsl;
    logic p_rbrk;
    logic p_dash;
    logic dot_block;
    logic t_sep;
    logic lit_hit;
    logic last_valid;
    logic cls_ok;
  } gpm_status_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
    return r;
  endfunction

endpackage

// ===== src/gpm_ctrl.sv =====
// Sequencer of the glob path matcher: accepts transactions and steps the match.
// Depends on gpm_pkg; drives gpm_dp through gpm_cmd_t and reads gpm_status_t.
module gpm_ctrl import gpm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  cmd_code,
  input  gpm_status_t st,
  output logic        busy,
  output gpm_cmd_t    dcmd
);

  gpm_state_t state, state_next;
  logic accept;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && cmd_code == CMD_EVAL && !st.ovf) state_next = S_FETCH;
      end
      S_FETCH: state_next = st.i_lt_n ? S_DECIDE : S_TAIL;
      S_DECIDE: begin
        if (!st.j_lt_m) state_next = S_BT;
        else if (st.p_star) state_next = st.dot_block ? S_BT : S_FETCH;
        else if (st.p_ques) state_next = (st.dot_block || st.t_sep) ? S_BT : S_FETCH;
        else if (st.p_lbrk) state_next = (st.dot_block || st.t_sep) ? S_BT : S_CLS_INV;
        else if (st.p_bsl && st.j1_lt_m) state_next = S_LIT;
        else state_next = st.lit_hit ? S_FETCH : S_BT;
      end
      S_LIT:       state_next = st.lit_hit ? S_FETCH : S_BT;
      S_BT:        state_next = st.pmark_zero ? S_IDLE : S_BT_CHK;
      S_BT_CHK:    state_next = st.t_sep ? S_IDLE : S_FETCH;
      S_CLS_INV:   state_next = S_CLS_STEP;
      S_CLS_STEP:  state_next = st.j1_lt_m ? S_CLS_ELEM : S_CLS_END;
      S_CLS_ELEM: begin
        if (st.p_rbrk) state_next = S_CLS_END;
        else if (st.last_valid && st.p_dash && st.j1_lt_m) state_next = S_CLS_RANGE;
        else state_next = S_CLS_STEP;
      end
      S_CLS_RANGE: state_next = S_CLS_STEP;
      S_CLS_END:   state_next = st.cls_ok ? S_FETCH : S_BT;
      S_TAIL:      state_next = st.j_lt_m ? S_TAIL_CHK : S_IDLE;
      S_TAIL_CHK:  state_next = st.p_star ? S_TAIL : S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    dcmd.op        = OP_NONE;
    dcmd.res_match = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd_code != CMD_EVAL) dcmd.op = OP_LOAD;
          else if (st.ovf)          dcmd.op = OP_FINISH;
          else                      dcmd.op = OP_INIT;
        end
      end
      S_FETCH: dcmd.op = st.i_lt_n ? OP_FETCH : OP_NONE;
      S_DECIDE: begin
        if (!st.j_lt_m) dcmd.op = OP_NONE;
        else if (st.p_star) dcmd.op = st.dot_block ? OP_NONE : OP_STAR;
        else if (st.p_ques) dcmd.op = (st.dot_block || st.t_sep) ? OP_NONE : OP_ADV;
        else if (st.p_lbrk) dcmd.op = (st.dot_block || st.t_sep) ? OP_NONE : OP_CLS_START;
        else if (st.p_bsl && st.j1_lt_m) dcmd.op = OP_ESC;
        else dcmd.op = st.lit_hit ? OP_LIT_ADV : OP_NONE;
      end
      S_LIT: dcmd.op = st.lit_hit ? OP_LIT_ADV : OP_NONE;
      S_BT:  dcmd.op = st.pmark_zero ? OP_FINISH : OP_BT_READ;
      S_BT_CHK: dcmd.op = st.t_sep ? OP_FINISH : OP_BT;
      S_CLS_INV:  dcmd.op = OP_CLS_INV;
      S_CLS_STEP: dcmd.op = OP_CLS_STEP;
      S_CLS_ELEM: begin
        if (st.p_rbrk) dcmd.op = OP_NONE;
        else if (st.last_valid && st.p_dash && st.j1_lt_m) dcmd.op = OP_RREAD;
        else dcmd.op = OP_CLS_ELEM;
      end
      S_CLS_RANGE: dcmd.op = st.p_rbrk ? OP_CLS_DASH : OP_CLS_RANGE;
      S_CLS_END:   dcmd.op = st.cls_ok ? OP_CLS_ADV : OP_NONE;
      S_TAIL: begin
        if (st.j_lt_m) dcmd.op = OP_TAIL_RD;
        else begin
          dcmd.op        = OP_FINISH;
          dcmd.res_match = 1'b1;
        end
      end
      S_TAIL_CHK: dcmd.op = st.p_star ? OP_JINC : OP_FINISH;
      default: dcmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== src/gpm_dp.sv =====
// Datapath of the glob path matcher: stores, cursors, class logic, result register.
// Depends on gpm_pkg; commanded by gpm_ctrl.
module gpm_dp import gpm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  gpm_item_t   item,
  input  gpm_cmd_t    dcmd,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_data,
  output gpm_status_t st,
  output logic        done,
  output gpm_result_t result
);

  logic [7:0] pmem [MAX_PATTERN];
  logic [7:0] tmem [MAX_TEXT];

  logic           dot_glob, case_fold;
  logic [7:0]     path_sep;
  logic [PLW-1:0] plen, j, p_mark;
  logic [TLW-1:0] tlen, i, t_mark;
  logic           povf, tovf, nodot;
  logic [7:0]     pd, td, tv, last;
  logic           last_valid, hit, invert;

  logic [PLW-1:0] j1;
  logic [PLW-1:0] paddr;
  logic [TLW-1:0] taddr;
  logic           p_rd, t_rd;
  logic [7:0]     fpd;

  assign j1  = j + 1'b1;
  assign fpd = fold(pd, case_fold);

  always_comb begin
    p_rd  = 1'b0;
    t_rd  = 1'b0;
    paddr = j;
    taddr = i;
    case (dcmd.op)
      OP_FETCH: begin
        p_rd = 1'b1;
        t_rd = 1'b1;
      end
      OP_TAIL_RD: p_rd = 1'b1;
      OP_ESC, OP_CLS_START, OP_CLS_STEP, OP_RREAD: begin
        p_rd  = 1'b1;
        paddr = j1;
      end
      OP_BT_READ: begin
        t_rd  = 1'b1;
        taddr = t_mark;
      end
      default: ;
    endcase
  end

  // stores: one write and one registered read each
  always_ff @(posedge clk) begin
    if (dcmd.op == OP_LOAD && item.cmd == CMD_PAT_BYTE && plen < PLW'(MAX_PATTERN))
      pmem[plen[PAW-1:0]] <= item.ch;
    if (dcmd.op == OP_LOAD && item.cmd == CMD_TXT_BYTE && tlen < TLW'(MAX_TEXT))
      tmem[tlen[TAW-1:0]] <= item.ch;
    if (p_rd) pd <= pmem[paddr[PAW-1:0]];
    if (t_rd) td <= tmem[taddr[TAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_glob  <= 1'b0;
      case_fold <= 1'b0;
      path_sep  <= SEP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DOT_GLOB:  dot_glob  <= cfg_data[0];
        REG_CASE_FOLD: case_fold <= cfg_data[0];
        REG_PATH_SEP:  path_sep  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= '0;
      povf <= 1'b0;
      tlen <= '0;
      tovf <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= (dcmd.op == OP_FINISH);
      if (dcmd.op == OP_LOAD) begin
        case (item.cmd)
          CMD_CLEAR: begin
            plen <= '0;
            povf <= 1'b0;
          end
          CMD_PAT_BYTE: begin
            if (plen < PLW'(MAX_PATTERN)) plen <= plen + 1'b1;
            else povf <= 1'b1;
          end
          CMD_TXT_BYTE: begin
            if (tlen < TLW'(MAX_TEXT)) tlen <= tlen + 1'b1;
            else tovf <= 1'b1;
          end
          default: ;
        endcase
      end
      if (dcmd.op == OP_FINISH) begin
        tlen <= '0;
        tovf <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.op == OP_FINISH) begin
      result.overflow <= povf || tovf;
      result.matched  <= dcmd.res_match && !(povf || tovf);
    end
  end

  // cursors and class scratch
  always_ff @(posedge clk) begin
    case (dcmd.op)
      OP_INIT: begin
        i      <= '0;
        j      <= '0;
        t_mark <= '0;
        p_mark <= '0;
        nodot  <= !dot_glob;
      end
      OP_STAR: begin
        t_mark <= i;
        j      <= j1;
        p_mark <= j1;
      end
      OP_ADV: begin
        i <= i + 1'b1;
        j <= j1;
      end
      OP_LIT_ADV: begin
        nodot <= !dot_glob && pd == CH_SLASH;
        i     <= i + 1'b1;
        j     <= j1;
      end
      OP_ESC, OP_CLS_STEP, OP_JINC: j <= j1;
      OP_CLS_START: begin
        tv         <= fold(td, case_fold);
        last_valid <= 1'b0;
        hit        <= 1'b0;
      end
      OP_CLS_INV: begin
        invert <= st.j1_lt_m && (pd == CH_CARET || pd == CH_BANG);
        if (st.j1_lt_m && (pd == CH_CARET || pd == CH_BANG)) j <= j1;
      end
      OP_CLS_ELEM: begin
        if (tv == fpd) hit <= 1'b1;
        last       <= fpd;
        last_valid <= 1'b1;
      end
      OP_CLS_RANGE: begin
        j <= j1;
        if (tv <= fpd && tv >= last) hit <= 1'b1;
        last <= fpd;
      end
      OP_CLS_DASH: begin
        if (tv == CH_DASH) hit <= 1'b1;
        last <= CH_DASH;
      end
      OP_CLS_ADV: begin
        i <= i + 1'b1;
        if (st.j_lt_m) j <= j1;
      end
      OP_BT: begin
        t_mark <= t_mark + 1'b1;
        i      <= t_mark + 1'b1;
        j      <= p_mark;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.ovf        = povf || tovf;
    st.i_lt_n     = i < tlen;
    st.j_lt_m     = j < plen;
    st.j1_lt_m    = j1 < plen;
    st.pmark_zero = (p_mark == '0);
    st.p_star     = pd == CH_STAR;
    st.p_ques     = pd == CH_QUES;
    st.p_lbrk     = pd == CH_LBRK;
    st.p_bsl      = pd == CH_BSL;
    st.p_rbrk     = pd == CH_RBRK;
    st.p_dash     = pd == CH_DASH;
    st.dot_block  = nodot && td == CH_DOT;
    st.t_sep      = td == path_sep;
    st.lit_hit    = (fpd == fold(td, case_fold)) || (pd == CH_SLASH && td == path_sep);
    st.last_valid = last_valid;
    st.cls_ok     = hit != invert;
  end

endmodule

// ===== src/glob_path_matcher_unit.sv =====
// Top level of the glob path matcher: sequencer plus datapath.
// Depends on gpm_pkg, gpm_ctrl and gpm_dp.
//
// Usage:
//  - Transactions enter on item (cmd, ch) when start is high and busy is low.
//    Clear, pattern-byte and text-byte transactions give no result; the block
//    stays ready for the next one straight away.
//  - An evaluate transaction raises busy while the match runs and ends with
//    one result on result, marked by done for exactly one cycle. There is no
//    back-pressure: take the result in that cycle or lose it.
//  - When an overflow is pending, an evaluate ends without running the match;
//    otherwise the run grows with the text bytes consumed by a literal or '?',
//    the members of each bracket class, each star retry and each trailing
//    star. Each step is bound by the single registered read port of each store.
//  - Configuration (dot_glob, case_fold, path_sep) goes in through cfg_we,
//    cfg_addr and cfg_data; write only while busy is low.
//  - Reset empties both stores, clears overflow flags and restores path_sep
//    to '/'. No clearing pass is needed.
module glob_path_matcher_unit import gpm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  gpm_item_t   item,
  output logic        done,
  output gpm_result_t result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_data
);

  gpm_cmd_t    dcmd;
  gpm_status_t st;

  // sequencer: hold busy from evaluate accept to result
  gpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd_code (item.cmd),
    .st       (st),
    .busy     (busy),
    .dcmd     (dcmd)
  );

  // datapath: stores, cursors, result register
  gpm_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .dcmd     (dcmd),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .st       (st),
    .done     (done),
    .result   (result)
  );

endmodule

// ===== src/gpm_checker.sv =====
// Port-level checks for the glob path matcher, bound to the top level.
// Depends on gpm_pkg and glob_path_matcher_unit.
module gpm_port_props import gpm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input gpm_item_t   item,
  input logic        done,
  input gpm_result_t result
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe raised while a match was still running");

  a_ovf_nomatch: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.matched && result.overflow))
    else $error("match reported with overflow");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("busy or strobe right after reset");

  a_load_noresult: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd != CMD_EVAL) |=> !done && !busy)
    else $error("load transaction produced a result or stalled");

endmodule

bind glob_path_matcher_unit gpm_port_props u_gpm_checker (.*);

// ===== test/gpm_checker.sv =====
// Checker for the glob path matcher: watches transactions, results and register writes.
// Depends on gpm_pkg; instantiated beside the block by tb_top.
`timescale 1ns / 1ps
module gpm_checker import gpm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  gpm_item_t   item,
  input  logic        done,
  input  gpm_result_t result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending
);

  logic [7:0]  pat [MAX_PATTERN];
  logic [7:0]  txt [MAX_TEXT];
  int          pat_len, txt_len;
  bit          pat_ovf, txt_ovf;
  bit          dotglob_q, fold_q;
  logic [7:0]  sep_q;
  gpm_result_t verdicts [$];

  assign pending = verdicts.size();

  function automatic int lower(logic [7:0] c);
    if (fold_q && c >= 8'h41 && c <= 8'h5A) return int'(c) + 32;
    return int'(c);
  endfunction

  // Star backtracking walk over the stored pattern and text.
  function automatic bit glob_hit();
    int i, j, tmark, pmark, tv, last;
    bit nodot, adv, hit, inv, h;
    logic [7:0] pc, tc;
    i = 0; j = 0; tmark = 0; pmark = 0;
    nodot = !dotglob_q;
    while (i < txt_len) begin
      adv = 0;
      if (j < pat_len) begin
        pc = pat[j];
        tc = txt[i];
        if (pc == CH_STAR) begin
          if (!(nodot && tc == CH_DOT)) begin
            tmark = i; j++; pmark = j; adv = 1;
          end
        end else if (pc == CH_QUES) begin
          if (!(nodot && tc == CH_DOT) && tc != sep_q) begin
            i++; j++; adv = 1;
          end
        end else if (pc == CH_LBRK) begin
          if (!(nodot && tc == CH_DOT) && tc != sep_q) begin
            tv = lower(tc);
            last = 256;
            hit = 0;
            inv = (j + 1 < pat_len) && (pat[j+1] == CH_CARET || pat[j+1] == CH_BANG);
            if (inv) j++;
            j++;
            while (j < pat_len && pat[j] != CH_RBRK) begin
              if (last < 256 && pat[j] == CH_DASH && j + 1 < pat_len &&
                  pat[j+1] != CH_RBRK) begin
                j++;
                h = tv <= lower(pat[j]) && tv >= last;
              end else begin
                h = tv == lower(pat[j]);
              end
              if (h) hit = 1;
              last = lower(pat[j]);
              j++;
            end
            if (hit != inv) begin
              i++;
              if (j < pat_len) j++;
              adv = 1;
            end
          end
        end else begin
          if (pc == CH_BSL && j + 1 < pat_len) begin
            j++;
            pc = pat[j];
          end
          if (lower(pc) == lower(tc) || (pc == CH_SLASH && tc == sep_q)) begin
            nodot = !dotglob_q && pc == CH_SLASH;
            i++; j++; adv = 1;
          end
        end
      end
      if (!adv) begin
        if (pmark == 0 || txt[tmark] == sep_q) return 0;
        tmark++;
        i = tmark;
        j = pmark;
      end
    end
    while (j < pat_len && pat[j] == CH_STAR) j++;
    return j >= pat_len;
  endfunction

  task automatic report(string what, gpm_result_t got, gpm_result_t want);
    $display("MISMATCH %s: got matched=%0b overflow=%0b, want matched=%0b overflow=%0b",
             what, got.matched, got.overflow, want.matched, want.overflow);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    gpm_result_t want;
    if (rst) begin
      pat_len <= 0; txt_len <= 0; pat_ovf <= 0; txt_ovf <= 0;
      dotglob_q <= 0; fold_q <= 0; sep_q <= SEP_RESET;
      verdicts.delete();
    end else begin
      // compare a result against the oldest outstanding verdict
      if (done) begin
        if (verdicts.size() == 0) begin
          report("unexpected result", result, '0);
        end else begin
          want = verdicts.pop_front();
          if (result.matched !== want.matched) report("matched", result, want);
          else if (result.overflow !== want.overflow) report("overflow", result, want);
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_DOT_GLOB:  dotglob_q <= cfg_data[0];
          REG_CASE_FOLD: fold_q    <= cfg_data[0];
          REG_PATH_SEP:  sep_q     <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (gpm_code_t'(item.cmd))
          CMD_CLEAR: begin
            pat_len <= 0; pat_ovf <= 0;
          end
          CMD_PAT_BYTE: begin
            if (pat_len < MAX_PATTERN) begin
              pat[pat_len] <= item.ch; pat_len <= pat_len + 1;
            end else pat_ovf <= 1;
          end
          CMD_TXT_BYTE: begin
            if (txt_len < MAX_TEXT) begin
              txt[txt_len] <= item.ch; txt_len <= txt_len + 1;
            end else txt_ovf <= 1;
          end
          CMD_EVAL: begin
            want.overflow = pat_ovf || txt_ovf;
            want.matched  = !want.overflow && glob_hit();
            verdicts.push_back(want);
            txt_len <= 0; txt_ovf <= 0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the glob path matcher testbench: clock, reset, stimulus and verdict.
// Depends on gpm_pkg, gpm_checker and the glob_path_matcher_unit RTL.
`timescale 1ns / 1ps
module tb_top import gpm_pkg::*;;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  gpm_item_t   item = '0;
  logic        done;
  gpm_result_t result;
  logic        cfg_we = 0;
  logic [1:0]  cfg_addr = '0;
  logic [7:0]  cfg_data = '0;
  int          errors, pending;
  int          cycles = 0;
  int          sent = 0;
  int          idle_pct = 0;
  logic [7:0]  cur_sep = SEP_RESET;

  always #5 clk = ~clk;

  glob_path_matcher_unit uut (
    .clk, .rst, .start, .busy, .item, .done, .result, .cfg_we, .cfg_addr, .cfg_data
  );

  gpm_checker chk (
    .clk, .rst, .start, .busy, .item, .done, .result, .cfg_we, .cfg_addr, .cfg_data,
    .errors, .pending
  );

  // Watchdog: a hung match must not hang the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one transaction and hold it until the block takes it. Start stays
  // high on return so back-to-back transactions need no second assignment.
  task automatic send(gpm_code_t code, logic [7:0] b);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start    <= 1;
    item.cmd <= code;
    item.ch  <= b;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic send_str(gpm_code_t code, string s);
    foreach (s[k]) send(code, s[k]);
  endtask

  task automatic run_case(string p, string t);
    send(CMD_CLEAR, 8'h00);
    send_str(CMD_PAT_BYTE, p);
    send_str(CMD_TXT_BYTE, t);
    send(CMD_EVAL, 8'($urandom_range(0, 255)));
  endtask

  // Hold off until every verdict is in, then let the block settle.
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Only called once drained, so the block is idle.
  task automatic set_regs(bit dg, bit cf, logic [7:0] sp);
    cfg_we <= 1; cfg_addr <= REG_DOT_GLOB; cfg_data <= {7'd0, dg};
    @(posedge clk);
    cfg_addr <= REG_CASE_FOLD; cfg_data <= {7'd0, cf};
    @(posedge clk);
    cfg_addr <= REG_PATH_SEP; cfg_data <= sp;
    @(posedge clk);
    cfg_we <= 0;
    cur_sep = sp;
  endtask

  function automatic logic [7:0] pat_char();
    string letters;
    letters = "aAbB";
    case ($urandom_range(0, 11))
      0, 1: return CH_STAR;
      2:    return CH_QUES;
      3:    return CH_LBRK;
      4:    return CH_RBRK;
      5:    return $urandom_range(0, 1) ? CH_CARET : CH_BANG;
      6:    return CH_DASH;
      7:    return CH_BSL;
      8:    return CH_DOT;
      9:    return CH_SLASH;
      10:   return 8'($urandom_range(0, 255));
      default: return letters[$urandom_range(0, 3)];
    endcase
  endfunction

  function automatic logic [7:0] txt_char();
    string letters;
    letters = "aAbBc";
    case ($urandom_range(0, 9))
      0:    return CH_DOT;
      1:    return cur_sep;
      2:    return CH_SLASH;
      3:    return pat_char();
      4:    return 8'($urandom_range(0, 255));
      default: return letters[$urandom_range(0, 4)];
    endcase
  endfunction

  // One well-formed sequence: optionally new pattern, then a path, then evaluate.
  // Mostly short; now and then a full-size or overflowing store.
  task automatic random_sequence();
    int plen, tlen;
    plen = $urandom_range(0, 8);
    tlen = $urandom_range(0, 14);
    if ($urandom_range(0, 59) == 0) plen = $urandom_range(50, MAX_PATTERN);
    if ($urandom_range(0, 59) == 0) tlen = $urandom_range(200, MAX_TEXT);
    if ($urandom_range(0, 149) == 0) plen = MAX_PATTERN + 1;
    if ($urandom_range(0, 149) == 0) tlen = MAX_TEXT + 2;
    if ($urandom_range(0, 3) != 0) begin
      send(CMD_CLEAR, 8'($urandom_range(0, 255)));
      repeat (plen) send(CMD_PAT_BYTE, pat_char());
    end
    repeat (tlen) send(CMD_TXT_BYTE, txt_char());
    send(CMD_EVAL, 8'($urandom_range(0, 255)));
  endtask

  // Raw noise: any command, any byte.
  task automatic noise();
    repeat ($urandom_range(1, 6))
      send(gpm_code_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int goal;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty, stars, class forms, escapes, leading dots, separator.
    run_case("", "");
    run_case("**", "");
    run_case("*.c", "a/b.c");
    run_case("a?[!x-z]\\*", "ab9*");
    run_case("[^a", ".");
    run_case("x\\", "x\\");
    drain();
    set_regs(1, 1, 8'h00);
    // path with a zero separator byte inside it
    send(CMD_CLEAR, 8'h00);
    send_str(CMD_PAT_BYTE, "*/[A-C]");
    send(CMD_TXT_BYTE, "Q");
    send(CMD_TXT_BYTE, 8'h00);
    send(CMD_TXT_BYTE, "b");
    send(CMD_EVAL, 8'h00);
    run_case("*", ".hidden");
    drain();
    set_regs(0, 0, 8'hFF);
    cur_sep = 8'hFF;

    // Random phases: each with its own register setting and sender idling.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin set_regs(0, 0, SEP_RESET); idle_pct = 25; end
        1: begin set_regs(1, 1, 8'hFF);     idle_pct = 83; end
        2: begin set_regs(0, 1, 8'h00);     idle_pct = 0;  end
        default: begin
          set_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 3) == 0 ? SEP_RESET : 8'($urandom_range(0, 255)));
          idle_pct = 0;
        end
      endcase
      goal = sent + 500;
      while (sent < goal) begin
        if ($urandom_range(0, 9) == 0) noise();
        else random_sequence();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
